/* rtl/flptw_pkg.sv */
package flptw_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_XLATE = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ROOT_ZERO = 3'd1;
  localparam logic [2:0] ST_ABSENT    = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_LARGE     = 3'd4;

  localparam logic [1:0] KIND_4K = 2'd0;
  localparam logic [1:0] KIND_2M = 2'd1;
  localparam logic [1:0] KIND_1G = 2'd2;

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_DIR  = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef enum logic [1:0] {
    CMD_IMM,
    CMD_WRITE,
    CMD_XLATE,
    CMD_UNMAP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic [2:0]   imm_status;
    logic [39:0]  root_frame;
    logic [47:0]  virtual_address;
    logic [14:0]  word_index;
    logic [63:0]  word_value;
  } cmd_t;

  typedef enum logic [1:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_WALK,
    BE_EMIT
  } be_state_t;

  function automatic logic [8:0] lvl_idx(input logic [47:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      LVL_TOP:  idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_DIR:  idx = va[29:21];
      LVL_LEAF: idx = va[20:12];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

/* rtl/flptw_front.sv */
module flptw_front #(
  parameter int STORE_FRAMES = 64
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [175:0]      in_tdata,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output flptw_pkg::cmd_t   cmd
);
  import flptw_pkg::*;

  localparam int STORE_WORDS = STORE_FRAMES * 512;

  logic [1:0]  opcode;
  logic [39:0] root_frame;
  logic [31:0] widx_ext;
  logic        root_zero;
  logic        root_out;
  logic        widx_out;

  assign opcode             = in_tdata[1:0];
  assign root_frame         = in_tdata[41:2];

  assign widx_ext  = {17'd0, in_tdata[104:90]};
  assign root_zero = (root_frame == 40'd0);
  assign root_out  = (root_frame >= 40'(STORE_FRAMES));
  assign widx_out  = (widx_ext >= 32'(STORE_WORDS));

  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    cmd.root_frame      = root_frame;
    cmd.virtual_address = in_tdata[89:42];
    cmd.word_index      = in_tdata[104:90];
    cmd.word_value      = in_tdata[168:105];
    cmd.kind            = CMD_IMM;
    cmd.imm_status      = ST_OK;
    case (opcode)
      OP_WRITE: begin
        if (widx_out) begin
          cmd.imm_status = ST_OUTSIDE;
        end else begin
          cmd.kind = CMD_WRITE;
        end
      end
      OP_XLATE, OP_UNMAP: begin
        if (root_zero) begin
          cmd.imm_status = ST_ROOT_ZERO;
        end else if (root_out) begin
          cmd.imm_status = ST_OUTSIDE;
        end else if (opcode == OP_XLATE) begin
          cmd.kind = CMD_XLATE;
        end else begin
          cmd.kind = CMD_UNMAP;
        end
      end
      default: begin
        cmd.kind       = CMD_IMM;
        cmd.imm_status = ST_OK;
      end
    endcase
  end

endmodule

/* rtl/flptw_fifo.sv */
module flptw_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  flptw_pkg::cmd_t  push_data,
  input  logic             pop,
  output flptw_pkg::cmd_t  head,
  output logic             full,
  output logic             empty
);
  import flptw_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/flptw_back.sv */
module flptw_back #(
  parameter int STORE_FRAMES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  flptw_pkg::cmd_t  head,
  input  logic             q_empty,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             res_success,
  output logic [51:0]      res_pa,
  output logic [2:0]       res_status,
  output logic [1:0]       res_level,
  output logic [1:0]       res_kind
);
  import flptw_pkg::*;

  localparam int STORE_WORDS = STORE_FRAMES * 512;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

  logic [63:0] mem [STORE_WORDS];

  be_state_t   state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]  level_r, level_nxt;
  logic [47:0] va_r, va_nxt;
  logic        unmap_r, unmap_nxt;
  logic [63:0] rd_data_r;

  logic        res_success_r, res_success_nxt;
  logic [51:0] res_pa_r, res_pa_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [1:0]  res_level_r, res_level_nxt;
  logic [1:0]  res_kind_r, res_kind_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [63:0]       mem_wd;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [63:0] ent;
  logic        absent;
  logic        is_leaf;
  logic        is_large;
  logic [39:0] nxt_frame;
  logic        nxt_out;
  logic        walk_done;
  logic [1:0]  level_inc;
  logic [48:0] root_full;
  logic [48:0] next_full;
  logic [31:0] widx_ext;
  logic        is_walk;

  assign ent       = rd_data_r;
  assign absent    = !ent[BIT_PRESENT];
  assign is_leaf   = (level_r == LVL_LEAF);
  assign is_large  = (level_r != LVL_TOP) && ent[BIT_LARGE];
  assign nxt_frame = ent[51:12];
  assign nxt_out   = (nxt_frame >= 40'(STORE_FRAMES));
  assign walk_done = absent || is_leaf || is_large || nxt_out;
  assign level_inc = level_r + 2'd1;
  assign root_full = {head.root_frame, lvl_idx(head.virtual_address, LVL_TOP)};
  assign next_full = {nxt_frame, lvl_idx(va_r, level_inc)};
  assign widx_ext  = {17'd0, head.word_index};
  assign is_walk   = (head.kind == CMD_XLATE) || (head.kind == CMD_UNMAP);

  assign pop         = (state_r == BE_IDLE) && !q_empty;
  assign clearing    = (state_r == BE_CLEAR);
  assign out_valid   = (state_r == BE_EMIT);
  assign res_success = res_success_r;
  assign res_pa      = res_pa_r;
  assign res_status  = res_status_r;
  assign res_level   = res_level_r;
  assign res_kind    = res_kind_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (!q_empty) begin
          state_nxt = is_walk ? BE_WALK : BE_EMIT;
        end
      end
      BE_WALK: begin
        if (walk_done) begin
          state_nxt = BE_EMIT;
        end
      end
      BE_EMIT: begin
        if (out_ready) begin
          state_nxt = BE_IDLE;
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_nxt     = clr_cnt_r;
    addr_nxt        = addr_r;
    level_nxt       = level_r;
    va_nxt          = va_r;
    unmap_nxt       = unmap_r;
    res_success_nxt = res_success_r;
    res_pa_nxt      = res_pa_r;
    res_status_nxt  = res_status_r;
    res_level_nxt   = res_level_r;
    res_kind_nxt    = res_kind_r;
    mem_we          = 1'b0;
    mem_wa          = clr_cnt_r;
    mem_wd          = 64'd0;
    rd_en           = 1'b0;
    rd_addr         = root_full[ADDR_W-1:0];
    case (state_r)
      BE_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      BE_IDLE: begin
        if (!q_empty) begin
          res_success_nxt = 1'b0;
          res_pa_nxt      = 52'd0;
          res_status_nxt  = head.imm_status;
          res_level_nxt   = LVL_TOP;
          res_kind_nxt    = KIND_4K;
          va_nxt          = head.virtual_address;
          unmap_nxt       = (head.kind == CMD_UNMAP);
          level_nxt       = LVL_TOP;
          addr_nxt        = root_full[ADDR_W-1:0];
          case (head.kind)
            CMD_WRITE: begin
              mem_we          = 1'b1;
              mem_wa          = widx_ext[ADDR_W-1:0];
              mem_wd          = head.word_value;
              res_success_nxt = 1'b1;
              res_status_nxt  = ST_OK;
            end
            CMD_XLATE, CMD_UNMAP: begin
              rd_en = 1'b1;
            end
            default: begin
              res_success_nxt = 1'b0;
            end
          endcase
        end
      end
      BE_WALK: begin
        res_success_nxt = 1'b0;
        res_pa_nxt      = 52'd0;
        res_status_nxt  = ST_OK;
        res_level_nxt   = level_r;
        res_kind_nxt    = KIND_4K;
        if (absent) begin
          res_status_nxt = ST_ABSENT;
        end else if (is_leaf) begin
          res_success_nxt = 1'b1;
          if (unmap_r) begin
            mem_we = 1'b1;
            mem_wa = addr_r;
          end else begin
            res_pa_nxt = {ent[51:12], va_r[11:0]};
          end
        end else if (is_large) begin
          if (unmap_r) begin
            res_status_nxt = ST_LARGE;
          end else if (level_r == LVL_PDPT) begin
            res_success_nxt = 1'b1;
            res_pa_nxt      = {ent[51:30], va_r[29:0]};
            res_kind_nxt    = KIND_1G;
          end else begin
            res_success_nxt = 1'b1;
            res_pa_nxt      = {ent[51:21], va_r[20:0]};
            res_kind_nxt    = KIND_2M;
          end
        end else if (nxt_out) begin
          res_status_nxt = ST_OUTSIDE;
          res_level_nxt  = level_inc;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = next_full[ADDR_W-1:0];
          addr_nxt  = next_full[ADDR_W-1:0];
          level_nxt = level_inc;
        end
      end
      BE_EMIT: begin
        res_success_nxt = res_success_r;
      end
      default: begin
        res_success_nxt = res_success_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BE_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    level_r       <= level_nxt;
    va_r          <= va_nxt;
    unmap_r       <= unmap_nxt;
    res_success_r <= res_success_nxt;
    res_pa_r      <= res_pa_nxt;
    res_status_r  <= res_status_nxt;
    res_level_r   <= res_level_nxt;
    res_kind_r    <= res_kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/four_level_page_table_walker_top.sv */
// Four-level page table walker over a local store of STORE_FRAMES table frames of 512
// 64-bit entries each. Every item carries an opcode: write one table word, translate a
// 48-bit virtual address from a root frame, or unmap a present 4 KiB leaf entry; each
// item gives exactly one result. After reset the store is swept to zero at one word a
// cycle over all STORE_FRAMES*512 words (32768 at the default), and no item is taken
// during the sweep. A front stage classifies items into a two-entry queue; the back end
// owns the store with one write and one registered read port. A translate or unmap
// goes from queue head through issue of the root-entry read, one dependent table read
// per level reached and the result; writes and early faults go from issue to the result.
module four_level_page_table_walker_top #(
  parameter int STORE_FRAMES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, root_frame, virtual_address, word_index, word_value
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // success, physical_address, status, fault_level, page_kind
  output logic [63:0]  out_tdata
);
  import flptw_pkg::*;

  cmd_t        push_cmd;
  cmd_t        head;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic        clearing;
  logic        res_success;
  logic [51:0] res_pa;
  logic [2:0]  res_status;
  logic [1:0]  res_level;
  logic [1:0]  res_kind;

  flptw_front #(
    .STORE_FRAMES(STORE_FRAMES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .cmd       (push_cmd)
  );

  flptw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  flptw_back #(
    .STORE_FRAMES(STORE_FRAMES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .res_success (res_success),
    .res_pa      (res_pa),
    .res_status  (res_status),
    .res_level   (res_level),
    .res_kind    (res_kind)
  );

  assign out_tdata = {4'd0, res_kind, res_level, res_status, res_pa, res_success};

endmodule
